FILE: hw/rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Shared widths, limits and constants for the factorizer and its divider.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int LIMIT_W     = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 5'd30;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EVAL = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

endpackage

FILE: hw/rtl/tdf_div.sv
// ----------------------------------------------------------------------------
// Radix-2 shift divider
// Restoring division, one quotient bit per cycle; quotient and remainder are
// held after o_done until the next start.
// ----------------------------------------------------------------------------
module tdf_div #(
    parameter int W = tdf_pkg::VALUE_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dsr, n_dsr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so W bits hold it.
            n_rem = ge ? diff[W-1:0] : trial[W-1:0];
            n_quo = {r_quo[W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: hw/rtl/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// Trial division factorizer
// Emits the prime factors of each input number in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall, i_number) takes one number; the block
// holds o_stall high while it factors it. Each prime factor leaves on the
// output channel (o_valid, i_stall) as one transfer, repeated by multiplicity,
// with o_is_last on the final one. A number below 2 gives a single transfer
// with o_no_factor set and o_factor zero. At most factor_limit factors are
// sent per number (0 counts as 1, 31 as 30), written on the cfg channel.
// Each trial divisor costs one pass of the radix-2 divider, and each factor
// sent also passes through the push state. Divisors run from 2 up to the
// square root of the remaining value.
// A finished factor waits in the output register while the receiver stalls;
// the next one is computed meanwhile and holds until that register frees.
// Synchronous active-low reset empties the output register, returns the
// engine to idle and sets factor_limit to 10.
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
    parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tdf_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [VALUE_WIDTH-1:0]       i_number,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [VALUE_WIDTH-1:0]       o_factor,
    output logic                         o_no_factor,
    output logic                         o_is_last
);

    localparam int LW = tdf_pkg::LIMIT_W;

    tdf_pkg::t_state r_state, n_state;

    logic [LW-1:0]          r_limit, n_limit;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_div, n_div;
    logic [LW-1:0]          r_cnt, n_cnt;

    logic [VALUE_WIDTH-1:0] r_pend_factor, n_pend_factor;
    logic                   r_pend_nf, n_pend_nf;
    logic                   r_pend_last, n_pend_last;

    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_factor, n_out_factor;
    logic                   r_out_nf, n_out_nf;
    logic                   r_out_last, n_out_last;

    logic [LW-1:0]          limit_eff;
    logic                   in_take;
    logic                   out_free;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_mod;
    logic                   hit_last;

    assign limit_eff = (r_limit == '0) ? LW'(1) :
                       (r_limit > tdf_pkg::LIMIT_MAX) ? tdf_pkg::LIMIT_MAX : r_limit;

    assign o_stall     = (r_state != tdf_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_valid && (r_state == tdf_pkg::S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;

    // A factor closes the run when the quotient is one or the limit is reached.
    assign hit_last = (div_quo == VALUE_WIDTH'(1)) || ((r_cnt + 1'b1) == limit_eff);

    always_comb begin
        n_state       = r_state;
        n_limit       = r_limit;
        n_rem         = r_rem;
        n_div         = r_div;
        n_cnt         = r_cnt;
        n_pend_factor = r_pend_factor;
        n_pend_nf     = r_pend_nf;
        n_pend_last   = r_pend_last;
        div_start     = 1'b0;

        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end

        case (r_state)
            tdf_pkg::S_IDLE: begin
                if (in_take) begin
                    n_div = VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR);
                    n_cnt = '0;
                    n_rem = i_number;
                    if (i_number < VALUE_WIDTH'(2)) begin
                        n_pend_factor = '0;
                        n_pend_nf     = 1'b1;
                        n_pend_last   = 1'b1;
                        n_state       = tdf_pkg::S_PUSH;
                    end else begin
                        div_start = 1'b1;
                        n_state   = tdf_pkg::S_DIV;
                    end
                end
            end
            tdf_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = tdf_pkg::S_EVAL;
                end
            end
            tdf_pkg::S_EVAL: begin
                n_pend_nf = 1'b0;
                if (div_quo < r_div) begin
                    // Divisor squared exceeds the remainder, so it is prime.
                    n_pend_factor = r_rem;
                    n_pend_last   = 1'b1;
                    n_rem         = VALUE_WIDTH'(1);
                    n_state       = tdf_pkg::S_PUSH;
                end else if (div_mod == '0) begin
                    n_pend_factor = r_div;
                    n_pend_last   = hit_last;
                    n_rem         = div_quo;
                    n_cnt         = r_cnt + 1'b1;
                    n_state       = tdf_pkg::S_PUSH;
                end else begin
                    n_div     = r_div + 1'b1;
                    div_start = 1'b1;
                    n_state   = tdf_pkg::S_DIV;
                end
            end
            tdf_pkg::S_PUSH: begin
                if (out_free) begin
                    if (r_pend_last) begin
                        n_state = tdf_pkg::S_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = tdf_pkg::S_DIV;
                    end
                end
            end
            default: begin
                n_state = tdf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_factor = r_out_factor;
        n_out_nf     = r_out_nf;
        n_out_last   = r_out_last;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == tdf_pkg::S_PUSH) && out_free) begin
            n_out_valid  = 1'b1;
            n_out_factor = r_pend_factor;
            n_out_nf     = r_pend_nf;
            n_out_last   = r_pend_last;
        end
    end

    tdf_div #(
        .W (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (n_rem),
        .i_divisor   (n_div),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_mod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdf_pkg::S_IDLE;
            r_limit     <= tdf_pkg::LIMIT_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_rem         <= n_rem;
        r_div         <= n_div;
        r_pend_factor <= n_pend_factor;
        r_pend_nf     <= n_pend_nf;
        r_pend_last   <= n_pend_last;
        r_out_factor  <= n_out_factor;
        r_out_nf      <= n_out_nf;
        r_out_last    <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_factor    = r_out_factor;
    assign o_no_factor = r_out_nf;
    assign o_is_last   = r_out_last;

`ifndef SYNTHESIS
    a_cnt_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tdf_pkg::S_IDLE) |-> (r_cnt <= limit_eff))
        else $error("factor count exceeds the limit");

    a_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdf_pkg::S_DIV) |-> (r_div >= VALUE_WIDTH'(2) && r_rem >= VALUE_WIDTH'(2)))
        else $error("divider running on an operand below two");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == tdf_pkg::S_DIV))
        else $error("divider finished outside a division pass");
`endif

endmodule
